[rtl/bam_pkg.sv]
// Shared types and codes for the battery ADC monitor.
package bam_pkg;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_VOLT = 2'd1;
  localparam logic [1:0] CMD_TEMP = 2'd2;

  localparam logic [1:0] TBL_PERCENT = 2'd0;
  localparam logic [1:0] TBL_VOLT    = 2'd1;
  localparam logic [1:0] TBL_TEMP    = 2'd2;
  localparam int unsigned NUM_TABLES = 3;

  // The moving-average depth is a power of two, so the average is a shift.
  localparam int AVG_DEPTH = 4;

  localparam logic [1:0] HEALTH_GOOD = 2'd0;
  localparam logic [1:0] HEALTH_COLD = 2'd1;
  localparam logic [1:0] HEALTH_HOT  = 2'd2;

  localparam logic [2:0] REG_PERCENT_POINTS = 3'd0;
  localparam logic [2:0] REG_VOLTAGE_POINTS = 3'd1;
  localparam logic [2:0] REG_TEMP_POINTS    = 3'd2;
  localparam logic [2:0] REG_COLD_ENTER     = 3'd3;
  localparam logic [2:0] REG_COLD_EXIT      = 3'd4;
  localparam logic [2:0] REG_HOT_EXIT       = 3'd5;
  localparam logic [2:0] REG_HOT_ENTER      = 3'd6;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         table_select;
    logic [3:0]         point_index;
    logic [11:0]        point_adc;
    logic signed [31:0] point_value;
    logic [11:0]        adc_sample;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic [11:0]        averaged_count;
    logic signed [31:0] level_value;
    logic signed [31:0] charge_value;
    logic [1:0]         health_state;
    logic               health_changed;
  } out_t;

  typedef struct packed {
    logic [11:0]        adc;
    logic signed [31:0] value;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_MAP_INIT,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_FETCH_C,
    ST_SEARCH,
    ST_SLOPE,
    ST_SLOPE_WAIT,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_t;

endpackage

[rtl/bam_tab.sv]
// Threshold point memory for the three mapping tables, registered read.
module bam_tab
  import bam_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [$clog2(3*MAX_POINTS)-1:0]       waddr,
  input  entry_t                                wdata,
  input  logic [$clog2(3*MAX_POINTS)-1:0]       raddr,
  output entry_t                                rdata
);

  localparam int DEPTH = NUM_TABLES * MAX_POINTS;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/bam_div.sv]
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
module bam_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [12:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [31:0] q_r;
  logic [12:0] rem_r;
  logic [12:0] dmag_r;
  logic        neg_r;
  logic        done_r;
  logic [31:0] quot_r;
  logic [13:0] rem_sh;
  logic        ge;
  logic [13:0] rem_nxt;
  logic [31:0] q_nxt;

  always_comb begin
    rem_sh  = {rem_r, q_r[31]};
    ge      = rem_sh >= {1'b0, dmag_r};
    rem_nxt = ge ? (rem_sh - {1'b0, dmag_r}) : rem_sh;
    q_nxt   = {q_r[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend[31] ? (32'd0 - dividend) : dividend;
        dmag_r <= divisor[12] ? (13'd0 - divisor) : divisor;
        neg_r  <= dividend[31] ^ divisor[12];
        rem_r  <= '0;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt[12:0];
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= neg_r ? (32'd0 - q_nxt) : q_nxt;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

[rtl/battery_adc_monitor.sv]
// Battery ADC monitor: moving average, table mapping and temperature health.
// A load request is written at its accept edge and busy stays low. A sample request holds
// busy through the averaging and one table mapping (temperature) or two (voltage), each a
// binary search plus, when the segment needs it, the shared one-bit-per-cycle slope divider.
// The result strobe follows in the next cycle, when a new request may be accepted.
// Synchronous active-low reset clears rings, sums and health and loads the configuration defaults.
module battery_adc_monitor
  import bam_pkg::*;
#(
  parameter int MAX_POINTS = 16,
  parameter int ADC_BITS   = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N_W    = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = $clog2(3 * MAX_POINTS);
  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W  = 12 + SLOT_W + 1;
  localparam logic [11:0] ADC_MASK = 12'((64'd1 << ADC_BITS) - 64'd1);

  // Configuration registers
  logic [4:0]         pts_r [NUM_TABLES];
  logic signed [31:0] cold_enter_r, cold_exit_r, hot_exit_r, hot_enter_r;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r[0]     <= 5'd2;
      pts_r[1]     <= 5'd2;
      pts_r[2]     <= 5'd2;
      cold_enter_r <= -32'sd5000;
      cold_exit_r  <= 32'sd0;
      hot_exit_r   <= 32'sd40000;
      hot_enter_r  <= 32'sd45000;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_PERCENT_POINTS: pts_r[0]     <= pwdata[4:0];
        REG_VOLTAGE_POINTS: pts_r[1]     <= pwdata[4:0];
        REG_TEMP_POINTS:    pts_r[2]     <= pwdata[4:0];
        REG_COLD_ENTER:     cold_enter_r <= pwdata;
        REG_COLD_EXIT:      cold_exit_r  <= pwdata;
        REG_HOT_EXIT:       hot_exit_r   <= pwdata;
        REG_HOT_ENTER:      hot_enter_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_PERCENT_POINTS: prdata = {27'd0, pts_r[0]};
      REG_VOLTAGE_POINTS: prdata = {27'd0, pts_r[1]};
      REG_TEMP_POINTS:    prdata = {27'd0, pts_r[2]};
      REG_COLD_ENTER:     prdata = cold_enter_r;
      REG_COLD_EXIT:      prdata = cold_exit_r;
      REG_HOT_EXIT:       prdata = hot_exit_r;
      REG_HOT_ENTER:      prdata = hot_enter_r;
      default:            prdata = 32'd0;
    endcase
  end

  // Sequencer state and datapath registers
  state_t             state_r, state_nxt;
  logic               kind_r;
  logic               pass_r;
  logic [11:0]        sample_r;
  logic [11:0]        avg_r;
  logic [1:0]         tsel_r;
  logic [N_W-1:0]     n_r, lo_r, hi_r;
  logic               fin_r;
  entry_t             ent_a_r, ent_b_r;
  logic [11:0]        start_r;
  logic signed [31:0] base_r, slope_r, prod_r, level_r, charge_r;
  logic [1:0]         health_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic [11:0]        ring_r [2][AVG_DEPTH];
  logic [SLOT_W-1:0]  slot_r [2];
  logic [SUM_W-1:0]   sum_r  [2];

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Table memory
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_waddr, tbl_raddr;
  entry_t            tbl_wdata, tbl_rdata;

  assign tbl_we = accept && (in_data.command == CMD_LOAD) &&
                  (32'(in_data.table_select) < NUM_TABLES) &&
                  (32'(in_data.point_index) < MAX_POINTS);
  assign tbl_waddr = ADDR_W'(32'(in_data.table_select) * MAX_POINTS +
                             32'(in_data.point_index));
  assign tbl_wdata = '{adc: in_data.point_adc & ADC_MASK, value: in_data.point_value};

  bam_tab #(.MAX_POINTS(MAX_POINTS)) u_tab (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Search index arithmetic
  logic [N_W:0]   mid_sum;
  logic [N_W-1:0] mid, k, idx_a, idx_b;
  logic           k_top;

  always_comb begin
    mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
    mid     = mid_sum[N_W:1];
    k       = fin_r ? lo_r : mid;
    k_top   = (k >= n_r);
    idx_a   = k_top ? (n_r - 1'b1) : ((k == '0) ? '0 : (k - 1'b1));
    idx_b   = k_top ? (n_r - 1'b1) : k;
    tbl_raddr = ADDR_W'(32'(tsel_r) * MAX_POINTS +
                        32'((state_r == ST_FETCH_A) ? idx_a : idx_b));
  end

  // Segment evaluation
  logic [11:0]        seg_start, seg_end;
  logic               below, above;
  logic [N_W-1:0]     lo_nxt, hi_nxt;
  logic signed [12:0] ar;
  logic signed [31:0] vr;
  logic               slope_div;

  always_comb begin
    seg_start = (k == '0) ? 12'd0 : ent_a_r.adc;
    seg_end   = (k == '0) ? ent_a_r.adc : ent_b_r.adc;
    below     = avg_r < seg_start;
    above     = !k_top && (avg_r >= seg_end);
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    if (below) begin
      hi_nxt = (mid == lo_r) ? lo_r : (mid - 1'b1);
    end else if (above) begin
      lo_nxt = mid + 1'b1;
    end else begin
      lo_nxt = mid;
      hi_nxt = mid;
    end
    ar        = $signed({1'b0, ent_b_r.adc}) - $signed({1'b0, ent_a_r.adc});
    vr        = ent_b_r.value - ent_a_r.value;
    slope_div = (k != '0) && !k_top && (ar != 13'sd0);
  end

  // Moving average
  logic [SUM_W-1:0] sum_nxt;
  always_comb begin
    sum_nxt = sum_r[kind_r] - SUM_W'(ring_r[kind_r][slot_r[kind_r]]) + SUM_W'(sample_r);
  end

  // Shared divider: one slope per mapping
  logic               div_start, div_done;
  logic signed [31:0] div_quot;

  always_comb begin
    div_start = (state_r == ST_SLOPE) && slope_div;
  end

  bam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (vr),
    .divisor  (ar),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Point count clamp and health update
  logic [N_W-1:0]     n_clamp;
  logic signed [31:0] map_res;
  logic [1:0]         health_nxt;

  always_comb begin
    if (pts_r[tsel_r] < 5'd2) begin
      n_clamp = N_W'(2);
    end else if (32'(pts_r[tsel_r]) > MAX_POINTS) begin
      n_clamp = N_W'(MAX_POINTS);
    end else begin
      n_clamp = N_W'(pts_r[tsel_r]);
    end
    map_res    = base_r + prod_r;
    health_nxt = health_r;
    if (level_r <= cold_enter_r) health_nxt = HEALTH_COLD;
    if (level_r >= hot_enter_r)  health_nxt = HEALTH_HOT;
    if (level_r >= cold_exit_r && level_r <= hot_exit_r) health_nxt = HEALTH_GOOD;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.command == CMD_VOLT || in_data.command == CMD_TEMP)) begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG:        state_nxt = ST_MAP_INIT;
      ST_MAP_INIT:   state_nxt = ST_FETCH_A;
      ST_FETCH_A:    state_nxt = ST_FETCH_B;
      ST_FETCH_B:    state_nxt = ST_FETCH_C;
      ST_FETCH_C:    state_nxt = fin_r ? ST_SLOPE : ST_SEARCH;
      ST_SEARCH:     state_nxt = ST_FETCH_A;
      ST_SLOPE:      state_nxt = slope_div ? ST_SLOPE_WAIT : ST_MUL;
      ST_SLOPE_WAIT: if (div_done) state_nxt = ST_MUL;
      ST_MUL:        state_nxt = ST_ADD;
      ST_ADD:        state_nxt = (!pass_r && !kind_r) ? ST_MAP_INIT : ST_OUT;
      ST_OUT:        state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      health_r    <= HEALTH_GOOD;
      for (int c = 0; c < 2; c++) begin
        slot_r[c] <= '0;
        sum_r[c]  <= '0;
        for (int i = 0; i < AVG_DEPTH; i++) begin
          ring_r[c][i] <= '0;
        end
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_OUT);
      if (state_r == ST_AVG) begin
        ring_r[kind_r][slot_r[kind_r]] <= sample_r;
        sum_r[kind_r]                  <= sum_nxt;
        slot_r[kind_r] <= (32'(slot_r[kind_r]) == AVG_DEPTH - 1) ? '0
                          : (slot_r[kind_r] + 1'b1);
      end
      if (state_r == ST_OUT && kind_r) begin
        health_r <= health_nxt;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        kind_r   <= (in_data.command == CMD_TEMP);
        sample_r <= in_data.adc_sample & ADC_MASK;
        tsel_r   <= (in_data.command == CMD_TEMP) ? TBL_TEMP : TBL_VOLT;
        pass_r   <= 1'b0;
        charge_r <= 32'sd0;
      end
      ST_AVG: avg_r <= 12'(sum_nxt >> SLOT_W);
      ST_MAP_INIT: begin
        n_r   <= n_clamp;
        lo_r  <= '0;
        hi_r  <= n_clamp;
        fin_r <= 1'b0;
      end
      ST_FETCH_B: ent_a_r <= tbl_rdata;
      ST_FETCH_C: ent_b_r <= tbl_rdata;
      ST_SEARCH: begin
        lo_r  <= lo_nxt;
        hi_r  <= hi_nxt;
        fin_r <= (lo_nxt == hi_nxt);
      end
      ST_SLOPE: begin
        start_r <= seg_start;
        base_r  <= ent_a_r.value;
        slope_r <= 32'sd0;
      end
      ST_SLOPE_WAIT: if (div_done) slope_r <= div_quot;
      ST_MUL: begin
        prod_r <= 32'(($signed({1'b0, avg_r}) - $signed({1'b0, start_r})) * slope_r);
      end
      ST_ADD: begin
        if (!pass_r) begin
          level_r <= map_res;
          tsel_r  <= TBL_PERCENT;
          pass_r  <= 1'b1;
        end else begin
          charge_r <= map_res;
        end
      end
      ST_OUT: begin
        out_data_r.result_kind    <= kind_r;
        out_data_r.averaged_count <= avg_r;
        out_data_r.level_value    <= level_r;
        out_data_r.charge_value   <= charge_r;
        out_data_r.health_state   <= kind_r ? health_nxt : health_r;
        out_data_r.health_changed <= kind_r && (health_nxt != health_r);
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[test/battery_adc_monitor_tb.sv]
// Self-checking testbench for the battery ADC monitor: directed table, then random requests.
`timescale 1ns / 1ps

module battery_adc_monitor_tb
  import bam_pkg::*;
();

  localparam int NPTS = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_valid;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  battery_adc_monitor dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block's state and registers.
  logic [4:0]         n_points [NUM_TABLES];
  logic signed [31:0] cold_enter_r, cold_exit_r, hot_exit_r, hot_enter_r;
  logic [11:0]        v_ring [4];
  logic [11:0]        t_ring [4];
  logic [1:0]         v_slot, t_slot;
  logic [13:0]        v_sum, t_sum;
  logic [11:0]        tbl_adc [NUM_TABLES][NPTS];
  logic signed [31:0] tbl_val [NUM_TABLES][NPTS];
  logic [1:0]         health_r;

  out_t expected_results[$];
  int   errors = 0;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } row_t;

  function automatic void seg_params(int t, int n, int k, output longint s_lo,
                                     output longint s_hi, output bit bounded,
                                     output logic [31:0] base, output logic [31:0] slope);
    longint ar;
    logic signed [31:0] vr;
    bounded = 1'b1;
    slope = '0;
    if (k == 0) begin
      s_lo = 0;
      s_hi = tbl_adc[t][0];
      base = tbl_val[t][0];
    end else if (k >= n) begin
      s_lo = tbl_adc[t][n-1];
      s_hi = 0;
      bounded = 1'b0;
      base = tbl_val[t][n-1];
    end else begin
      ar = longint'(tbl_adc[t][k]) - longint'(tbl_adc[t][k-1]);
      vr = tbl_val[t][k] - tbl_val[t][k-1];
      s_lo = tbl_adc[t][k-1];
      s_hi = tbl_adc[t][k];
      base = tbl_val[t][k-1];
      if (ar != 0) slope = 32'(longint'(vr) / ar);
    end
  endfunction

  function automatic logic [31:0] interpolate(int t, logic [4:0] cnt, logic [11:0] v);
    int n, lo, hi, mid;
    longint s_lo, s_hi;
    bit bounded;
    logic [31:0] base, slope, off;
    n = cnt;
    if (n < 2) n = 2;
    if (n > NPTS) n = NPTS;
    lo = 0;
    hi = n;
    while (lo != hi) begin
      mid = (lo + hi) / 2;
      seg_params(t, n, mid, s_lo, s_hi, bounded, base, slope);
      if (longint'(v) < s_lo) begin
        hi = (mid == lo) ? lo : mid - 1;
      end else if (bounded && longint'(v) >= s_hi) begin
        lo = mid + 1;
      end else begin
        lo = mid;
        break;
      end
    end
    seg_params(t, n, lo, s_lo, s_hi, bounded, base, slope);
    off = 32'(longint'(v) - s_lo);
    return base + off * slope;
  endfunction

  // Updates the shadow state for one accepted request; returns 1 if it yields a result.
  function automatic bit apply_request(in_t r, output out_t res);
    logic [11:0] avg;
    logic signed [31:0] tv;
    logic [1:0] h;
    res = '0;
    case (r.command)
      CMD_LOAD: begin
        if (r.table_select != 2'd3) begin
          tbl_adc[r.table_select][r.point_index] = r.point_adc;
          tbl_val[r.table_select][r.point_index] = r.point_value;
        end
        return 1'b0;
      end
      CMD_VOLT: begin
        v_sum = v_sum - v_ring[v_slot] + r.adc_sample;
        v_ring[v_slot] = r.adc_sample;
        v_slot = v_slot + 2'd1;
        avg = v_sum / 4;
        res.result_kind = 1'b0;
        res.averaged_count = avg;
        res.level_value = interpolate(TBL_VOLT, n_points[TBL_VOLT], avg);
        res.charge_value = interpolate(TBL_PERCENT, n_points[TBL_PERCENT], avg);
        res.health_state = health_r;
        res.health_changed = 1'b0;
        return 1'b1;
      end
      CMD_TEMP: begin
        t_sum = t_sum - t_ring[t_slot] + r.adc_sample;
        t_ring[t_slot] = r.adc_sample;
        t_slot = t_slot + 2'd1;
        avg = t_sum / 4;
        tv = interpolate(TBL_TEMP, n_points[TBL_TEMP], avg);
        h = health_r;
        if (tv <= cold_enter_r) h = HEALTH_COLD;
        if (tv >= hot_enter_r) h = HEALTH_HOT;
        if (tv >= cold_exit_r && tv <= hot_exit_r) h = HEALTH_GOOD;
        res.result_kind = 1'b1;
        res.averaged_count = avg;
        res.level_value = tv;
        res.charge_value = '0;
        res.health_state = h;
        res.health_changed = (h != health_r);
        health_r = h;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Drives one request and waits for it to be taken; the typed result, if given, wins.
  task automatic send_request(in_t r, bit typed = 1'b0, out_t want = '0);
    out_t res;
    @(negedge clk);
    start <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    if (apply_request(r, res)) expected_results.push_back(typed ? want : res);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    pause_sender(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_PERCENT_POINTS: n_points[TBL_PERCENT] = value[4:0];
      REG_VOLTAGE_POINTS: n_points[TBL_VOLT] = value[4:0];
      REG_TEMP_POINTS:    n_points[TBL_TEMP] = value[4:0];
      REG_COLD_ENTER:     cold_enter_r = value;
      REG_COLD_EXIT:      cold_exit_r = value;
      REG_HOT_EXIT:       hot_exit_r = value;
      REG_HOT_ENTER:      hot_enter_r = value;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [4:0] pick_points();
    case ($urandom_range(0, 5))
      0: return 5'd0;
      1: return 5'd2;
      2: return 5'd16;
      3: return 5'd31;
      default: return 5'($urandom_range(1, 17));
    endcase
  endfunction

  function automatic logic [31:0] pick_threshold(int centre);
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'(centre + $urandom_range(0, 20000) - 10000);
    endcase
  endfunction

  task automatic new_setting();
    wait_drained();
    write_reg(REG_PERCENT_POINTS, 32'(pick_points()));
    write_reg(REG_VOLTAGE_POINTS, 32'(pick_points()));
    write_reg(REG_TEMP_POINTS, 32'(pick_points()));
    write_reg(REG_COLD_ENTER, pick_threshold(-5000));
    write_reg(REG_COLD_EXIT, pick_threshold(0));
    write_reg(REG_HOT_EXIT, pick_threshold(40000));
    write_reg(REG_HOT_ENTER, pick_threshold(45000));
  endtask

  function automatic in_t random_request();
    in_t r;
    int sel;
    r.command = CMD_VOLT;
    r.table_select = 2'($urandom_range(0, 3));
    r.point_index = 4'($urandom);
    r.point_adc = 12'($urandom);
    r.point_value = $urandom;
    r.adc_sample = 12'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 42) begin
      r.command = CMD_VOLT;
    end else if (sel < 84) begin
      r.command = CMD_TEMP;
    end else if (sel < 96) begin
      r.command = CMD_LOAD;
      // Mostly ascending tables with modest values, so the search covers real segments.
      if ($urandom_range(0, 2) != 0) begin
        r.point_adc = 12'(r.point_index * 256 + $urandom_range(0, 255));
        r.point_value = 32'(int'($urandom_range(0, 100000)) - 50000);
      end
    end else begin
      r.command = 2'd3;
    end
    return r;
  endfunction

  function automatic out_t typed_out(bit kind, logic [11:0] avg, int lvl, int chg,
                                     logic [1:0] h, bit chd);
    out_t o;
    o.result_kind = kind;
    o.averaged_count = avg;
    o.level_value = lvl;
    o.charge_value = chg;
    o.health_state = h;
    o.health_changed = chd;
    return o;
  endfunction

  function automatic in_t mk(logic [1:0] cmd, logic [1:0] tsel, logic [3:0] idx,
                             logic [11:0] padc, logic [31:0] pval, logic [11:0] smp);
    in_t r;
    r.command = cmd;
    r.table_select = tsel;
    r.point_index = idx;
    r.point_adc = padc;
    r.point_value = pval;
    r.adc_sample = smp;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_kind !== want.result_kind) begin
          $display("%0t: result_kind expected %0d got %0d", $time,
                   want.result_kind, out_data.result_kind);
          errors++;
        end
        if (out_data.averaged_count !== want.averaged_count) begin
          $display("%0t: averaged_count expected %0d got %0d", $time,
                   want.averaged_count, out_data.averaged_count);
          errors++;
        end
        if (out_data.level_value !== want.level_value) begin
          $display("%0t: level_value expected %0d got %0d", $time,
                   want.level_value, out_data.level_value);
          errors++;
        end
        if (out_data.charge_value !== want.charge_value) begin
          $display("%0t: charge_value expected %0d got %0d", $time,
                   want.charge_value, out_data.charge_value);
          errors++;
        end
        if (out_data.health_state !== want.health_state) begin
          $display("%0t: health_state expected %0d got %0d", $time,
                   want.health_state, out_data.health_state);
          errors++;
        end
        if (out_data.health_changed !== want.health_changed) begin
          $display("%0t: health_changed expected %0d got %0d", $time,
                   want.health_changed, out_data.health_changed);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    row_t dir_rows[$];
    row_t row;
    int quiet_lo, quiet_hi;

    n_points = '{5'd2, 5'd2, 5'd2};
    cold_enter_r = -5000;
    cold_exit_r = 0;
    hot_exit_r = 40000;
    hot_enter_r = 45000;
    v_ring = '{default: '0};
    t_ring = '{default: '0};
    v_slot = '0;
    t_slot = '0;
    v_sum = '0;
    t_sum = '0;
    health_r = HEALTH_GOOD;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every table entry is written before any sample reads one.
    for (int t = 0; t < NUM_TABLES; t++) begin
      for (int i = 0; i < NPTS; i++) begin
        send_request(mk(CMD_LOAD, 2'(t), 4'(i), 12'(256 * i + 128),
                        (t == TBL_PERCENT) ? 32'(1000 * i) :
                        (t == TBL_VOLT) ? 32'(3000 + 100 * i) : 32'(-20000 + 5000 * i),
                        '0));
      end
    end

    row = '{mk(CMD_VOLT, 0, 0, 0, 0, 12'd0), 1'b1,
            typed_out(0, 0, 3000, 0, HEALTH_GOOD, 0)};
    dir_rows.push_back(row);
    row = '{mk(CMD_TEMP, 0, 0, 0, 0, 12'd0), 1'b1,
            typed_out(1, 0, -20000, 0, HEALTH_COLD, 1)};
    dir_rows.push_back(row);
    row = '{mk(CMD_VOLT, 3, 15, 12'hfff, 32'hffff_ffff, 12'hfff), 1'b1,
            typed_out(0, 1023, 3100, 1000, HEALTH_COLD, 0)};
    dir_rows.push_back(row);
    row = '{mk(CMD_VOLT, 0, 0, 0, 0, 12'hfff), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_VOLT, 0, 0, 0, 0, 12'hfff), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_VOLT, 0, 0, 0, 0, 12'hfff), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_TEMP, 0, 0, 0, 0, 12'd300), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_TEMP, 0, 0, 0, 0, 12'hfff), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_TEMP, 0, 0, 0, 0, 12'hfff), 1'b0, '0};
    dir_rows.push_back(row);
    // Unused command and a load into the missing fourth table are ignored.
    row = '{mk(2'd3, 0, 0, 12'hfff, 32'h7fff_ffff, 12'hfff), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_LOAD, 2'd3, 4'd1, 12'd5, 32'h8000_0000, 0), 1'b0, '0};
    dir_rows.push_back(row);
    // Equal adc counts give a zero-width segment with slope zero.
    row = '{mk(CMD_LOAD, TBL_VOLT, 4'd1, 12'd128, 32'h7fff_ffff, 0), 1'b0, '0};
    dir_rows.push_back(row);
    // Extreme point values make the slope numerator wrap.
    row = '{mk(CMD_LOAD, TBL_PERCENT, 4'd1, 12'd4095, 32'h7fff_ffff, 0), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_LOAD, TBL_PERCENT, 4'd0, 12'd0, 32'h8000_0000, 0), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_VOLT, 0, 0, 0, 0, 12'd0), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_VOLT, 0, 0, 0, 0, 12'd2000), 1'b0, '0};
    dir_rows.push_back(row);
    // A descending temperature table makes the search stop at its lower bound.
    row = '{mk(CMD_LOAD, TBL_TEMP, 4'd0, 12'd3000, 32'd50000, 0), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_LOAD, TBL_TEMP, 4'd1, 12'd100, -32'sd10000, 0), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_TEMP, 0, 0, 0, 0, 12'd0), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_TEMP, 0, 0, 0, 0, 12'd1000), 1'b0, '0};
    dir_rows.push_back(row);
    row = '{mk(CMD_TEMP, 0, 0, 0, 0, 12'd4000), 1'b0, '0};
    dir_rows.push_back(row);

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // Extreme settings first, then a fresh random setting every few hundred requests.
    wait_drained();
    write_reg(REG_PERCENT_POINTS, 32'd16);
    write_reg(REG_VOLTAGE_POINTS, 32'd31);
    write_reg(REG_TEMP_POINTS, 32'd0);
    write_reg(REG_COLD_ENTER, 32'h8000_0000);
    write_reg(REG_COLD_EXIT, 32'h8000_0000);
    write_reg(REG_HOT_EXIT, 32'h7fff_ffff);
    write_reg(REG_HOT_ENTER, 32'h7fff_ffff);

    quiet_lo = 600;
    quiet_hi = 1000;
    for (int i = 0; i < 1750; i++) begin
      if (i % 300 == 299) new_setting();
      if ((i < quiet_lo || i > quiet_hi) && $urandom_range(0, 99) < 18)
        pause_sender($urandom_range(1, 40));
      send_request(random_request());
    end

    pause_sender(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
